// ===== rtl/n_digit_prime_search_top_defines.svh =====
// Assertion macros used by the checker file of the prime search block.
`ifndef N_DIGIT_PRIME_SEARCH_TOP_DEFINES_SVH
`define N_DIGIT_PRIME_SEARCH_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define NPSS_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("prime search check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define NPSS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("prime search check failed");

`endif

// ===== rtl/npss_pkg.sv =====
// Package of types, constants and tables for the prime search block.
package npss_pkg;

	localparam int MAX_DIGITS = 9;
	localparam int DIGIT_W    = 4;
	localparam int CAND_W     = 30;
	localparam int DIV_W      = 16;
	localparam int SQ_W       = 31;
	localparam int BIT_CNT_W  = $clog2(CAND_W);

	typedef struct packed {
		logic [DIGIT_W-1:0] digit_count;
		logic               search_down;
	} in_t;

	typedef struct packed {
		logic [CAND_W-1:0] prime_value;
		logic              found;
	} out_t;

	// Controller to datapath commands.
	typedef struct packed {
		logic load;
		logic div_start;
		logic div_step;
		logic next_div;
		logic next_cand;
		logic mark_prime;
	} cmd_t;

	// Datapath to controller status.
	typedef struct packed {
		logic range_ok;
		logic below_two;
		logic sq_over;
		logic div_last;
		logic rem_zero;
		logic at_end;
	} sts_t;

	// Smallest value with n decimal digits.
	function automatic logic [CAND_W-1:0] range_lo(input logic [DIGIT_W-1:0] n);
		logic [CAND_W-1:0] v;
		case (n)
			4'd1: v = 30'd1;
			4'd2: v = 30'd10;
			4'd3: v = 30'd100;
			4'd4: v = 30'd1000;
			4'd5: v = 30'd10000;
			4'd6: v = 30'd100000;
			4'd7: v = 30'd1000000;
			4'd8: v = 30'd10000000;
			4'd9: v = 30'd100000000;
			default: v = '0;
		endcase
		return v;
	endfunction

	// Largest value with n decimal digits.
	function automatic logic [CAND_W-1:0] range_hi(input logic [DIGIT_W-1:0] n);
		logic [CAND_W-1:0] v;
		case (n)
			4'd1: v = 30'd9;
			4'd2: v = 30'd99;
			4'd3: v = 30'd999;
			4'd4: v = 30'd9999;
			4'd5: v = 30'd99999;
			4'd6: v = 30'd999999;
			4'd7: v = 30'd9999999;
			4'd8: v = 30'd99999999;
			4'd9: v = 30'd999999999;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

// ===== rtl/npss_datapath.sv =====
// Candidate, divisor and serial remainder datapath of the prime search.
module npss_datapath import npss_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  in_t  req,
	input  cmd_t cmd,
	output sts_t sts,
	output out_t res
);

	logic [CAND_W-1:0]    cand_q;
	logic [CAND_W-1:0]    bound_q;
	logic                 down_q;
	logic                 range_ok_q;
	logic [DIV_W-1:0]     div_q;
	logic [SQ_W-1:0]      sq_q;
	logic [DIV_W-1:0]     rem_q;
	logic [BIT_CNT_W-1:0] cnt_q;
	out_t                 res_q;

	logic [DIV_W:0]       rem_sh;
	logic [DIV_W:0]       rem_sub;
	logic                 rem_ge;

	// Shift in one dividend bit, subtract the divisor when it fits.
	assign rem_sh  = {rem_q, cand_q[cnt_q]};
	assign rem_ge  = rem_sh >= {1'b0, div_q};
	assign rem_sub = rem_sh - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_ok_q <= 1'b0;
			down_q     <= 1'b0;
		end else if (cmd.load) begin
			range_ok_q <= (req.digit_count != '0) &&
				(req.digit_count <= DIGIT_W'(MAX_DIGITS));
			down_q     <= req.search_down;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cand_q  <= req.search_down ? range_hi(req.digit_count) : range_lo(req.digit_count);
			bound_q <= req.search_down ? range_lo(req.digit_count) : range_hi(req.digit_count);
			div_q   <= DIV_W'(2);
			sq_q    <= SQ_W'(4);
			res_q   <= '0;
		end else begin
			if (cmd.next_cand) begin
				cand_q <= down_q ? cand_q - 1'b1 : cand_q + 1'b1;
				div_q  <= DIV_W'(2);
				sq_q   <= SQ_W'(4);
			end else if (cmd.next_div) begin
				// (d+1)^2 = d^2 + 2d + 1
				div_q <= div_q + 1'b1;
				sq_q  <= sq_q + SQ_W'({div_q, 1'b1});
			end
			if (cmd.mark_prime) begin
				res_q.prime_value <= cand_q;
				res_q.found       <= 1'b1;
			end
		end
		if (cmd.div_start) begin
			rem_q <= '0;
			cnt_q <= BIT_CNT_W'(CAND_W - 1);
		end else if (cmd.div_step) begin
			rem_q <= rem_ge ? rem_sub[DIV_W-1:0] : rem_sh[DIV_W-1:0];
			cnt_q <= cnt_q - 1'b1;
		end
	end

	assign sts.range_ok  = range_ok_q;
	assign sts.below_two = cand_q < CAND_W'(2);
	assign sts.sq_over   = sq_q > {1'b0, cand_q};
	assign sts.div_last  = cnt_q == '0;
	assign sts.rem_zero  = rem_q == '0;
	assign sts.at_end    = cand_q == bound_q;
	assign res           = res_q;

endmodule

// ===== rtl/npss_ctrl.sv =====
// Sequencing state machine of the prime search.
module npss_ctrl import npss_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  sts_t sts,
	output cmd_t cmd,
	output logic busy,
	output logic done
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_TEST = 3'd1;
	localparam logic [2:0] ST_DIV  = 3'd2;
	localparam logic [2:0] ST_EVAL = 3'd3;
	localparam logic [2:0] ST_ADV  = 3'd4;
	localparam logic [2:0] ST_DONE = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = ST_TEST;
				end
			end
			ST_TEST: begin
				if (!sts.range_ok) begin
					state_d = ST_DONE;
				end else if (sts.below_two) begin
					state_d = ST_ADV;
				end else if (sts.sq_over) begin
					// no divisor up to the square root: prime
					cmd.mark_prime = 1'b1;
					state_d        = ST_DONE;
				end else begin
					cmd.div_start = 1'b1;
					state_d       = ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = ST_EVAL;
				end
			end
			ST_EVAL: begin
				if (sts.rem_zero) begin
					state_d = ST_ADV;
				end else begin
					cmd.next_div = 1'b1;
					state_d      = ST_TEST;
				end
			end
			ST_ADV: begin
				if (sts.at_end) begin
					state_d = ST_DONE;
				end else begin
					cmd.next_cand = 1'b1;
					state_d       = ST_TEST;
				end
			end
			ST_DONE: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = state_q != ST_IDLE;
	assign done = state_q == ST_DONE;

endmodule

// ===== rtl/n_digit_prime_search_top.sv =====
// Candidates are tested in turn from one end of the digit range; each takes trial
// divisors from two while their square does not exceed it, and the search stops at the
// first prime. Each trial division runs in the serial remainder unit, one dividend bit
// per cycle. A candidate below two is skipped; an invalid digit count ends with no result.
// Throughput: one transaction at a time; busy stays high through the result strobe cycle.
// Reset clears the controller to idle; busy and done are low after reset.
module n_digit_prime_search_top import npss_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  in_t  req,
	output logic done,
	output out_t rsp
);

	cmd_t cmd;
	sts_t sts;

	npss_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	npss_datapath u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.sts    (sts),
		.res    (rsp)
	);

endmodule

// ===== rtl/npss_checker.sv =====
// Port-level checker of the prime search, bound to the top level.
`include "n_digit_prime_search_top_defines.svh"

module npss_checker import npss_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input out_t rsp
);

	`NPSS_ASSERT_NEXT(a_accept_busy, start && !busy, busy && !done)
	`NPSS_ASSERT_NEXT(a_done_pulse, done, !done && !busy)
	`NPSS_ASSERT_SAME(a_none_zero, done && !rsp.found, rsp.prime_value == '0)
	`NPSS_ASSERT_SAME(a_found_ge_two, done && rsp.found, rsp.prime_value >= CAND_W'(2))

endmodule

bind n_digit_prime_search_top npss_checker u_npss_checker (.*);
